/* rtl/lpc_pkg.sv */
// Shared types and constants for the lidar point covariance pipeline.
package lpc_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int PROD_SHIFT      = 2 * COORD_FRAC_BITS;
  localparam int Z_FILL_RAW      = ((1 << COORD_FRAC_BITS) + 5000) / 10000;
  localparam logic [31:0] Z_FILL = (Z_FILL_RAW == 0) ? 32'd1 : 32'(Z_FILL_RAW);

  localparam int LANES     = 6;   // xx, xy, xz, yy, yz, zz
  localparam int DIV_STEPS = 32;

  localparam logic [LANES-1:0] LANE_DIAG = 6'b101001;

  localparam logic [15:0] RANGING_NOISE_RST = 16'd1311;
  localparam logic [31:0] BEARING_VAR_RST   = 32'd13083;

  localparam logic [47:0]        BEAR_CAP = 48'h8000_0000_0000;
  localparam logic signed [49:0] OUT_MAX  = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] OUT_MIN  = -50'sh0_8000_0000_0000;

  typedef enum logic [0:0] {
    CFG_RANGING_NOISE    = 1'b0,
    CFG_BEARING_VARIANCE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] cov_xx;
    logic signed [47:0] cov_xy;
    logic signed [47:0] cov_xz;
    logic signed [47:0] cov_yy;
    logic signed [47:0] cov_yz;
    logic signed [47:0] cov_zz;
  } out_item_t;

  // one covariance entry on its way through the divider
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] dvd;
    logic [31:0] quo;
    logic [47:0] bterm;
    logic        neg;
  } div_lane_t;

  typedef struct packed {
    logic [63:0]                 d;
    div_lane_t [LANES-1:0]       lane;
  } div_item_t;

endpackage

/* rtl/lpc_front.sv */
// Front stages: magnitudes, products, r^2, partial products and bearing term.
module lpc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  lpc_pkg::in_item_t in_data,
  input  logic [31:0]       rv,
  input  logic [31:0]       bv,
  output logic              div_valid,
  output lpc_pkg::div_item_t div_item
);
  import lpc_pkg::*;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  logic [4:0] v_r;

  // stage 1
  logic [31:0] a_r [3];
  logic [2:0]  sgn_r;
  // stage 2
  logic [63:0]      pr_r [LANES];
  logic [LANES-1:0] neg2_r;
  // stage 3
  logic [63:0]      prod3_r [LANES];
  logic [63:0]      bop3_r [LANES];
  logic [63:0]      r2_3_r;
  logic [LANES-1:0] neg3_r;
  // stage 4
  logic [63:0]      rl_r [LANES];
  logic [63:0]      rh_r [LANES];
  logic [63:0]      bl_r [LANES];
  logic [63:0]      bh_r [LANES];
  logic [63:0]      r2_4_r;
  logic [LANES-1:0] neg4_r;
  // stage 5
  logic [95:0]      n5_r [LANES];
  logic [95:0]      v5_r [LANES];
  logic [63:0]      r2_5_r;
  logic [LANES-1:0] neg5_r;
  // stage 6
  logic      div_valid_r;
  div_item_t div_item_r;

  logic [31:0] z_sel;
  div_item_t   div_item_nxt;

  assign z_sel = (in_data.point_z == 32'sd0) ? Z_FILL : in_data.point_z;

  always_comb begin
    logic [96:0] vr;
    logic [96:0] sh;
    div_item_nxt   = '0;
    div_item_nxt.d = r2_5_r;
    for (int k = 0; k < LANES; k++) begin
      vr = {1'b0, v5_r[k]} + (97'd1 << (PROD_SHIFT - 1));
      sh = vr >> PROD_SHIFT;
      div_item_nxt.lane[k].rem   = n5_r[k][95:32];
      div_item_nxt.lane[k].dvd   = n5_r[k][31:0];
      div_item_nxt.lane[k].quo   = '0;
      div_item_nxt.lane[k].bterm = (sh > {49'd0, BEAR_CAP}) ? BEAR_CAP : sh[47:0];
      div_item_nxt.lane[k].neg   = neg5_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      div_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[3:0], in_valid};
      div_valid_r <= v_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= mag32(in_data.point_x);
      a_r[1] <= mag32(in_data.point_y);
      a_r[2] <= mag32(z_sel);
      sgn_r  <= {z_sel[31], in_data.point_y[31], in_data.point_x[31]};

      pr_r[0] <= 64'(a_r[0]) * 64'(a_r[0]);
      pr_r[1] <= 64'(a_r[0]) * 64'(a_r[1]);
      pr_r[2] <= 64'(a_r[0]) * 64'(a_r[2]);
      pr_r[3] <= 64'(a_r[1]) * 64'(a_r[1]);
      pr_r[4] <= 64'(a_r[1]) * 64'(a_r[2]);
      pr_r[5] <= 64'(a_r[2]) * 64'(a_r[2]);
      neg2_r  <= {1'b0, sgn_r[1] ^ sgn_r[2], 1'b0,
                  sgn_r[0] ^ sgn_r[2], sgn_r[0] ^ sgn_r[1], 1'b0};

      r2_3_r <= pr_r[0] + pr_r[3] + pr_r[5];
      for (int k = 0; k < LANES; k++) begin
        prod3_r[k] <= pr_r[k];
      end
      // diagonal bearing term uses the other two squares
      bop3_r[0] <= pr_r[3] + pr_r[5];
      bop3_r[1] <= pr_r[1];
      bop3_r[2] <= pr_r[2];
      bop3_r[3] <= pr_r[0] + pr_r[5];
      bop3_r[4] <= pr_r[4];
      bop3_r[5] <= pr_r[0] + pr_r[3];
      neg3_r    <= neg2_r;

      for (int k = 0; k < LANES; k++) begin
        rl_r[k] <= 64'(rv) * 64'(prod3_r[k][31:0]);
        rh_r[k] <= 64'(rv) * 64'(prod3_r[k][63:32]);
        bl_r[k] <= 64'(bv) * 64'(bop3_r[k][31:0]);
        bh_r[k] <= 64'(bv) * 64'(bop3_r[k][63:32]);
      end
      r2_4_r <= r2_3_r;
      neg4_r <= neg3_r;

      for (int k = 0; k < LANES; k++) begin
        n5_r[k] <= 96'(rl_r[k]) + {rh_r[k], 32'd0};
        v5_r[k] <= 96'(bl_r[k]) + {bh_r[k], 32'd0};
      end
      r2_5_r <= r2_4_r;
      neg5_r <= neg4_r;

      div_item_r <= div_item_nxt;
    end
  end

  assign div_valid = div_valid_r;
  assign div_item  = div_item_r;

endmodule

/* rtl/lpc_div_step.sv */
// One restoring division step for all six lanes, one quotient bit each.
module lpc_div_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  lpc_pkg::div_item_t in_item,
  output logic               out_valid,
  output lpc_pkg::div_item_t out_item
);
  import lpc_pkg::*;

  logic      valid_r;
  div_item_t item_r;
  div_item_t item_nxt;

  // remainder stays below d, so the shifted value fits 65 bits
  always_comb begin
    logic [64:0] sh;
    logic [64:0] diff;
    logic        ge;
    item_nxt = in_item;
    for (int k = 0; k < LANES; k++) begin
      sh   = {in_item.lane[k].rem, in_item.lane[k].dvd[31]};
      diff = sh - {1'b0, in_item.d};
      ge   = (sh >= {1'b0, in_item.d});
      item_nxt.lane[k].rem = ge ? diff[63:0] : sh[63:0];
      item_nxt.lane[k].dvd = {in_item.lane[k].dvd[30:0], 1'b0};
      item_nxt.lane[k].quo = {in_item.lane[k].quo[30:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

/* rtl/lpc_back.sv */
// Back stages: quotient rounding, term combination and saturation.
module lpc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  lpc_pkg::div_item_t in_item,
  output logic               out_valid,
  output lpc_pkg::out_item_t out_data
);
  import lpc_pkg::*;

  logic             rnd_valid_r;
  logic [32:0]      t1_r [LANES];
  logic [47:0]      bterm_r [LANES];
  logic [LANES-1:0] neg_r;

  logic             out_valid_r;
  out_item_t        out_data_r;
  out_item_t        out_data_nxt;
  logic signed [47:0] sat [LANES];

  always_comb begin
    logic signed [49:0] t1s;
    logic signed [49:0] bs;
    logic signed [49:0] t;
    for (int k = 0; k < LANES; k++) begin
      t1s = $signed(50'(t1_r[k]));
      bs  = $signed(50'(bterm_r[k]));
      if (LANE_DIAG[k]) begin
        t = t1s + bs;
      end else if (neg_r[k]) begin
        t = bs - t1s;
      end else begin
        t = t1s - bs;
      end
      if (t > OUT_MAX) begin
        sat[k] = OUT_MAX[47:0];
      end else if (t < OUT_MIN) begin
        sat[k] = OUT_MIN[47:0];
      end else begin
        sat[k] = t[47:0];
      end
    end
    out_data_nxt.cov_xx = sat[0];
    out_data_nxt.cov_xy = sat[1];
    out_data_nxt.cov_xz = sat[2];
    out_data_nxt.cov_yy = sat[3];
    out_data_nxt.cov_yz = sat[4];
    out_data_nxt.cov_zz = sat[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      rnd_valid_r <= in_valid;
      out_valid_r <= rnd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        // round half away: bump when 2*rem >= d
        t1_r[k] <= {1'b0, in_item.lane[k].quo} +
                   33'({in_item.lane[k].rem, 1'b0} >= {1'b0, in_item.d});
        bterm_r[k] <= in_item.lane[k].bterm;
      end
      for (int k = 0; k < LANES; k++) begin
        neg_r[k] <= in_item.lane[k].neg;
      end
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/lidar_point_covariance_core.sv */
// Top level of the lidar point covariance pipeline.
//
//  port group | dir | carries
//  in_*       | in  | one point (x, y, z), valid/stall
//  out_*      | out | six covariance entries, valid/stall
//  cfg_*      | in  | register writes, no read-back
//
// One point per cycle unless the output stalls. Six front stages, 32 radix-2
// divider steps, rounding and an output register. Divider depth sets latency.
// Reset clears every valid bit and loads the register defaults.
// While the output register holds an unaccepted transfer the whole pipeline
// freezes and in_stall is raised; nothing is dropped or repeated.
module lidar_point_covariance_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lpc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lpc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import lpc_pkg::*;

  logic [15:0] ranging_noise_r;
  logic [31:0] bearing_variance_r;
  logic [31:0] rv_r;
  logic        en;

  logic      chain_v [DIV_STEPS+1];
  div_item_t chain   [DIV_STEPS+1];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ranging_noise_r    <= RANGING_NOISE_RST;
      bearing_variance_r <= BEARING_VAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANGING_NOISE:    ranging_noise_r    <= cfg_wdata[15:0];
        CFG_BEARING_VARIANCE: bearing_variance_r <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rv_r <= 32'(ranging_noise_r) * 32'(ranging_noise_r);
  end

  lpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .rv        (rv_r),
    .bv        (bearing_variance_r),
    .div_valid (chain_v[0]),
    .div_item  (chain[0])
  );

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    lpc_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (chain_v[g]),
      .in_item   (chain[g]),
      .out_valid (chain_v[g+1]),
      .out_item  (chain[g+1])
    );
  end

  lpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (chain_v[DIV_STEPS]),
    .in_item   (chain[DIV_STEPS]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* rtl/lpc_checker.sv */
// Port-level checks for the covariance core, bound to the top level.
module lpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input lpc_pkg::out_item_t out_data
);
  import lpc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled while output is free");

  a_diag_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.cov_xx[47] && !out_data.cov_yy[47] && !out_data.cov_zz[47])
    else $error("negative diagonal entry");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind lidar_point_covariance_core lpc_checker u_lpc_checker (.*);
